// ----- sv/xdfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdfd_pkg
// Types, codes and default sizes shared by the XOR delta frame decoder.
// ----------------------------------------------------------------------------
package xdfd_pkg;

  localparam int MAX_PIXELS_DEFAULT  = 65536;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] TYPE_KEY   = 8'h00;
  localparam logic [7:0] TYPE_DELTA = 8'h01;

  typedef enum logic [3:0] {
    PH_TYPE, PH_W_HI, PH_W_LO, PH_H_HI, PH_H_LO, PH_K_HI, PH_K_LO, PH_C_HI,
    PH_C_LO, PH_S_HI, PH_S_LO, PH_R_HI, PH_R_LO, PH_D_HI, PH_D_LO, PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_OVER    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [15:0] pixel_index;
    logic [15:0] pixel_value;
    logic        frame_done;
    status_t     frame_status;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } result_t;

  // Work handed from the parser to the pixel stage. For a key pixel
  // pixel_value is the stored word, for a delta pixel it is the XOR mask.
  typedef struct packed {
    logic    is_key;
    result_t res;
  } op_t;

endpackage

// ----- sv/xdfd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdfd_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module xdfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/xdfd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdfd_front
// Record parser: walks the header and body fields, tracks the cursor and
// frame status, and issues pixel and end-of-frame work to the queue.
// ----------------------------------------------------------------------------
module xdfd_front
  import xdfd_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT,
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  byte_item_t    byte_data,
  output logic          push_valid,
  input  logic          push_ready,
  output op_t           push_op,
  output logic [AW-1:0] push_addr
);

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int SW = ((CW > 16) ? CW : 16) + 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PIXELS);

  phase_t        phase, phase_next, phase_proc;
  status_t       status_held, status_next, status_proc;
  logic [7:0]    hi_hold, hi_hold_next;
  logic [7:0]    type_held, type_next;
  logic [15:0]   width_held, width_next;
  logic [15:0]   height_held, height_next;
  logic [15:0]   chunks_left, chunks_next;
  logic [15:0]   run_left, run_next;
  logic [CW-1:0] cursor, cursor_next;
  logic [CW-1:0] stored_size, stored_size_next;
  logic [31:0]   count_held, count_next;
  logic          size_load, size_load_next;

  logic          accept;
  logic [15:0]   word;
  logic [CW-1:0] cur_inc;
  logic [SW-1:0] skip_sum;
  logic [15:0]   chunks_dec;
  logic [15:0]   run_dec;
  logic          key_ok;
  logic          delta_ok;
  logic          pix;
  status_t       done_status;

  assign byte_ready = push_ready;
  assign accept     = byte_valid && byte_ready;
  assign word       = {hi_hold, byte_data.data_byte};
  assign cur_inc    = cursor + CW'(1);
  assign skip_sum   = SW'(cursor) + SW'(word);
  assign chunks_dec = chunks_left - 16'd1;
  assign run_dec    = run_left - 16'd1;
  assign key_ok     = cursor < MAX_C;
  assign delta_ok   = (cursor < stored_size) && (cursor < MAX_C);

  // next state
  always_comb begin
    phase_proc       = phase;
    status_proc      = status_held;
    hi_hold_next     = hi_hold;
    type_next        = type_held;
    width_next       = width_held;
    height_next      = height_held;
    chunks_next      = chunks_left;
    run_next         = run_left;
    cursor_next      = cursor;
    count_next       = count_held;
    stored_size_next = stored_size;
    size_load_next   = 1'b0;

    if (size_load) begin
      stored_size_next = (count_held > 32'(MAX_PIXELS)) ? MAX_C : count_held[CW-1:0];
    end

    if (accept) begin
      case (phase)
        PH_TYPE: begin
          type_next   = byte_data.data_byte;
          width_next  = 16'd0;
          height_next = 16'd0;
          status_proc = ST_OK;
          phase_proc  = PH_W_HI;
        end
        PH_W_HI: begin
          hi_hold_next = byte_data.data_byte;
          width_next   = {byte_data.data_byte, 8'h00};
          phase_proc   = PH_W_LO;
        end
        PH_W_LO: begin
          width_next = word;
          phase_proc = PH_H_HI;
        end
        PH_H_HI: begin
          hi_hold_next = byte_data.data_byte;
          height_next  = {byte_data.data_byte, 8'h00};
          phase_proc   = PH_H_LO;
        end
        PH_H_LO: begin
          height_next = word;
          count_next  = 32'(width_held) * 32'(word);
          cursor_next = '0;
          if (type_held == TYPE_KEY) begin
            size_load_next = 1'b1;
            phase_proc = (width_held == 16'd0 || word == 16'd0) ? PH_IDLE : PH_K_HI;
          end else if (type_held == TYPE_DELTA) begin
            phase_proc = PH_C_HI;
          end else begin
            status_proc = ST_UNKNOWN;
            phase_proc  = PH_IDLE;
          end
        end
        PH_K_HI: begin
          hi_hold_next = byte_data.data_byte;
          phase_proc   = PH_K_LO;
        end
        PH_K_LO: begin
          if (!key_ok) begin
            status_proc = ST_OVER;
            phase_proc  = PH_IDLE;
          end else begin
            cursor_next = cur_inc;
            if (32'(cur_inc) == count_held) begin
              phase_proc = PH_IDLE;
            end else if (cur_inc >= MAX_C) begin
              status_proc = ST_OVER;
              phase_proc  = PH_IDLE;
            end else begin
              phase_proc = PH_K_HI;
            end
          end
        end
        PH_C_HI: begin
          hi_hold_next = byte_data.data_byte;
          phase_proc   = PH_C_LO;
        end
        PH_C_LO: begin
          chunks_next = word;
          phase_proc  = (word == 16'd0) ? PH_IDLE : PH_S_HI;
        end
        PH_S_HI: begin
          hi_hold_next = byte_data.data_byte;
          phase_proc   = PH_S_LO;
        end
        PH_S_LO: begin
          cursor_next = (skip_sum >= SW'(MAX_PIXELS)) ? MAX_C : skip_sum[CW-1:0];
          phase_proc  = PH_R_HI;
        end
        PH_R_HI: begin
          hi_hold_next = byte_data.data_byte;
          phase_proc   = PH_R_LO;
        end
        PH_R_LO: begin
          run_next = word;
          if (word == 16'd0) begin
            chunks_next = chunks_dec;
            phase_proc  = (chunks_dec == 16'd0) ? PH_IDLE : PH_S_HI;
          end else begin
            phase_proc = PH_D_HI;
          end
        end
        PH_D_HI: begin
          hi_hold_next = byte_data.data_byte;
          phase_proc   = PH_D_LO;
        end
        PH_D_LO: begin
          if (!delta_ok) begin
            status_proc = ST_OVER;
            phase_proc  = PH_IDLE;
          end else begin
            cursor_next = cur_inc;
            run_next    = run_dec;
            if (run_dec == 16'd0) begin
              chunks_next = chunks_dec;
              phase_proc  = (chunks_dec == 16'd0) ? PH_IDLE : PH_S_HI;
            end else begin
              phase_proc = PH_D_HI;
            end
          end
        end
        default: begin
          phase_proc = PH_IDLE;
        end
      endcase
    end

    phase_next  = phase_proc;
    status_next = status_proc;
    if (accept && byte_data.last_byte) begin
      phase_next  = PH_TYPE;
      status_next = ST_OK;
    end
  end

  // outputs
  always_comb begin
    pix = accept && (((phase == PH_K_LO) && key_ok) || ((phase == PH_D_LO) && delta_ok));

    if (phase_proc == PH_IDLE) begin
      done_status = status_proc;
    end else if ((phase_proc == PH_TYPE || phase_proc == PH_W_HI || phase_proc == PH_W_LO ||
                  phase_proc == PH_H_HI || phase_proc == PH_H_LO) &&
                 (type_next > TYPE_DELTA)) begin
      done_status = ST_UNKNOWN;
    end else begin
      done_status = ST_TRUNC;
    end

    push_valid                = accept && (pix || byte_data.last_byte);
    push_addr                 = cursor[AW-1:0];
    push_op.is_key            = (phase == PH_K_LO);
    push_op.res.pixel_valid   = pix;
    push_op.res.pixel_index   = pix ? 16'(cursor) : 16'd0;
    push_op.res.pixel_value   = pix ? word : 16'd0;
    push_op.res.frame_done    = byte_data.last_byte;
    push_op.res.frame_status  = byte_data.last_byte ? done_status : ST_OK;
    push_op.res.frame_width   = byte_data.last_byte ? width_next : 16'd0;
    push_op.res.frame_height  = byte_data.last_byte ? height_next : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      status_held <= ST_OK;
      hi_hold     <= 8'h00;
      type_held   <= 8'h00;
      width_held  <= 16'd0;
      height_held <= 16'd0;
      chunks_left <= 16'd0;
      run_left    <= 16'd0;
      cursor      <= '0;
      stored_size <= '0;
      count_held  <= 32'd0;
      size_load   <= 1'b0;
    end else begin
      phase       <= phase_next;
      status_held <= status_next;
      hi_hold     <= hi_hold_next;
      type_held   <= type_next;
      width_held  <= width_next;
      height_held <= height_next;
      chunks_left <= chunks_next;
      run_left    <= run_next;
      cursor      <= cursor_next;
      stored_size <= stored_size_next;
      count_held  <= count_next;
      size_load   <= size_load_next;
    end
  end

endmodule

// ----- sv/xdfd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdfd_queue
// Small register FIFO of pixel and end-of-frame work between the parser and the pixel stage.
// ----------------------------------------------------------------------------
module xdfd_queue
  import xdfd_pkg::*;
#(
  parameter int AW    = 16,
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  op_t           push_op,
  input  logic [AW-1:0] push_addr,
  output logic          pop_valid,
  input  logic          pop_ready,
  output op_t           pop_op,
  output logic [AW-1:0] pop_addr
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  op_t           ops   [DEPTH];
  logic [AW-1:0] addrs [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push, do_pop;

  assign push_ready = (fill != NW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_op     = ops[rd_ptr];
  assign pop_addr   = addrs[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ops[wr_ptr]   <= push_op;
      addrs[wr_ptr] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

// ----- sv/xdfd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdfd_back
// Pixel stage: stores key pixels, read-modify-writes delta pixels in the
// pixel store with a bypass of the latest write, and drives the result item.
// ----------------------------------------------------------------------------
module xdfd_back
  import xdfd_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT,
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  op_t           pop_op,
  input  logic [AW-1:0] pop_addr,
  output logic          res_valid,
  input  logic          res_ready,
  output result_t       res_data
);

  logic          s1_valid;
  op_t           s1_op;
  logic [AW-1:0] s1_addr;
  logic          lw_valid;
  logic [AW-1:0] lw_addr;
  logic [15:0]   lw_data;
  logic          out_valid;
  result_t       out_data;

  logic          s1_go;
  logic          do_pop;
  logic          rd_en;
  logic          wr_en;
  logic [15:0]   rd_data;
  logic [15:0]   old_value;
  logic [15:0]   new_value;
  result_t       s1_res;

  assign s1_go     = s1_valid && (!out_valid || res_ready);
  assign pop_ready = !s1_valid || s1_go;
  assign do_pop    = pop_valid && pop_ready;
  assign rd_en     = do_pop && pop_op.res.pixel_valid && !pop_op.is_key;
  assign wr_en     = s1_go && s1_op.res.pixel_valid;
  assign old_value = (lw_valid && lw_addr == s1_addr) ? lw_data : rd_data;
  assign new_value = s1_op.is_key ? s1_op.res.pixel_value
                                  : (old_value ^ s1_op.res.pixel_value);

  always_comb begin
    s1_res             = s1_op.res;
    s1_res.pixel_value = s1_op.res.pixel_valid ? new_value : 16'd0;
  end

  xdfd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (new_value),
    .rd_en   (rd_en),
    .rd_addr (pop_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (do_pop) begin
      s1_op   <= pop_op;
      s1_addr <= pop_addr;
    end
    if (wr_en) begin
      lw_addr <= s1_addr;
      lw_data <= new_value;
    end
    if (s1_go) begin
      out_data <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      lw_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop_ready) begin
        s1_valid <= pop_valid;
      end
      if (wr_en) begin
        lw_valid <= 1'b1;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (res_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res_valid = out_valid;
  assign res_data  = out_data;

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_addr) && $stable(s1_op))
    else $error("pixel stage lost its item while stalled");

  a_no_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pixel_valid |->
      out_data.pixel_index == 16'd0 && out_data.pixel_value == 16'd0)
    else $error("pixel fields set on an item without a pixel write");

  a_no_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.frame_done |->
      out_data.frame_status == ST_OK && out_data.frame_width == 16'd0 &&
      out_data.frame_height == 16'd0)
    else $error("frame fields set on an item that does not end a frame");

endmodule

// ----- sv/xor_delta_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_delta_frame_decoder
// Decodes key and XOR delta frame records one byte per item into pixel
// writes and end-of-frame status.
// ----------------------------------------------------------------------------
// The decoder takes one record byte every clock cycle, sustained, for as long
// as results are taken; each byte makes at most one read-modify-write of the
// pixel store, whose one read and one write port with a bypass of the latest
// write carry one pixel per cycle. Each accepted byte's work passes through a
// short work queue, the pixel stage register and the output register, and the
// queue keeps a stalled result side from stopping the parser at once. The
// pixel store holds MAX_PIXELS words and has no reset and no clearing pass:
// a delta frame should follow a complete key frame.
module xor_delta_frame_decoder
  import xdfd_pkg::*;
#(
  parameter int MAX_PIXELS  = MAX_PIXELS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_data,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res_data
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic          push_valid, push_ready;
  op_t           push_op;
  logic [AW-1:0] push_addr;
  logic          pop_valid, pop_ready;
  op_t           pop_op;
  logic [AW-1:0] pop_addr;

  xdfd_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .push_addr  (push_addr)
  );

  xdfd_queue #(
    .AW    (AW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .push_addr  (push_addr),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op),
    .pop_addr   (pop_addr)
  );

  xdfd_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .pop_addr  (pop_addr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule
